@@ design/tsl2_pkg.sv @@
// Types and constants shared by the split scorer modules.
package tsl2_pkg;

   localparam int unsigned SumWidth = 48;

   typedef struct packed {
      logic signed [31:0] obs_value;
      logic signed [31:0] grad_value;
      logic               sample_last;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] split_score;
      logic        rejected;
      logic [16:0] left_total;
      logic [16:0] right_total;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MODE      = 2'd1,
      CSR_MIN_LEAF  = 2'd2,
      CSR_OUT_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_READ,
      ST_TERM,
      ST_DIV,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Request to the divider and its answer.
   typedef struct packed {
      logic         start;
      logic [95:0]  dividend;
      logic [36:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic         done;
      logic [63:0]  quotient;
      logic         overflow;
   } div_rsp_type;

endpackage

@@ design/tsl2_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
module tsl2_ram #(
   parameter int unsigned Width = 48,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tsl2_divider.sv @@
// Restoring divider: floor(dividend / divisor), one quotient bit per cycle.
module tsl2_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tsl2_pkg::div_req_type req,
   output tsl2_pkg::div_rsp_type rsp
);

   logic [95:0] num_ff, num_in;
   logic [36:0] den_ff, den_in;
   logic [37:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic        ovf_ff, ovf_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [37:0] trial;
   logic [38:0] diff;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[36:0], num_ff[95]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         num_in  = req.dividend;
         den_in  = req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = 7'd96;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[94:0], 1'b0};
         if (!diff[38]) begin
            rem_in = diff[37:0];
         end else begin
            rem_in = trial;
         end
         if (quo_ff[63]) begin
            ovf_in = 1'b1;
         end
         quo_in = {quo_ff[62:0], ~diff[38]};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.overflow = ovf_ff;

endmodule

@@ design/tree_split_l2_scorer_top.sv @@
// Top level of the L2 split scorer: accumulation, scoring sequencer and result port.
//
// Channel | Ports                      | Beat
// req     | start, busy, req_beat      | one gradient component
// rsp     | rsp_valid, rsp_beat        | one split score
// csr     | csr_we, csr_index, csr_data| one register write
//
// For a beat, the accepting cycle reads the side sum and the next writes it back.
// On the final beat a scoring pass runs: per active component and side, a read, the
// magnitude and the square, then a divide (none for an empty side); then a clearing
// sweep of all MAX_OUTPUTS entries runs before the result beat. A rejected split skips
// the scoring and goes straight to the clearing sweep.
// Synchronous reset clears control state and registers; sums start at zero
// through the clearing sweep that reset starts. The result is shown for one
// cycle; busy is high in every state but accumulation, and low when it is shown.
module tree_split_l2_scorer_top #(
   parameter int unsigned MAX_OUTPUTS = 16,
   parameter int unsigned MAX_SAMPLES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tsl2_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   output tsl2_pkg::rsp_beat_type rsp_beat,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   localparam int unsigned AW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SW = tsl2_pkg::SumWidth;
   localparam logic [SW-1:0] SumMax = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SumMin = {1'b1, {(SW-1){1'b0}}};

   logic signed [31:0] thr_ff;
   logic               mode_ff;
   logic [16:0]        min_ff;
   logic [4:0]         ocnt_ff;

   tsl2_pkg::state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   comp_ff, comp_in;
   logic          side_ff, side_in;
   logic          last_ff, last_in;
   logic signed [31:0] grad_ff, grad_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [63:0]   score_ff, score_in;
   logic [95:0]   sq_ff, sq_in;
   logic [47:0]   mag_ff, mag_in;
   logic [1:0]    ph_ff, ph_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tsl2_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic          l_we, r_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [SW-1:0] wr_data, l_rd, r_rd, cur;
   logic [SW:0]   acc;
   logic [AW:0]   n_act;
   tsl2_pkg::div_req_type dreq;
   tsl2_pkg::div_rsp_type drsp;
   logic [64:0]   sum65;
   logic          go_right, rej;
   logic [47:0]   pa, pb;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         mode_ff <= 1'b0;
         min_ff  <= '0;
         ocnt_ff <= 5'd1;
      end else if (csr_we) begin
         case (tsl2_pkg::csr_index_type'(csr_index))
            tsl2_pkg::CSR_THRESHOLD: thr_ff  <= csr_data;
            tsl2_pkg::CSR_MODE:      mode_ff <= csr_data[0];
            tsl2_pkg::CSR_MIN_LEAF:  min_ff  <= csr_data[16:0];
            tsl2_pkg::CSR_OUT_COUNT: ocnt_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ocnt_ff == 5'd0) begin
         n_act = (AW+1)'(1);
      end else if (32'(ocnt_ff) > MAX_OUTPUTS) begin
         n_act = (AW+1)'(MAX_OUTPUTS);
      end else begin
         n_act = (AW+1)'(ocnt_ff);
      end
   end

   tsl2_ram #(.Width(SW), .Depth(MAX_OUTPUTS)) u_left (
      .clock(clock), .wr_en(l_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(l_rd));

   tsl2_ram #(.Width(SW), .Depth(MAX_OUTPUTS)) u_right (
      .clock(clock), .wr_en(r_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(r_rd));

   tsl2_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign go_right = mode_ff ? (req_beat.obs_value == thr_ff)
                             : (req_beat.obs_value > thr_ff);
   assign cur = side_ff ? r_rd : l_rd;
   assign acc = {cur[SW-1], cur} + (SW+1)'(grad_ff);
   assign rej = (32'(lcnt_ff) < 32'(min_ff)) || (32'(rcnt_ff) < 32'(min_ff));
   assign pa  = {24'd0, mag_ff[47:24]};
   assign pb  = {24'd0, mag_ff[23:0]};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      comp_in      = comp_ff;
      side_in      = side_ff;
      last_in      = last_ff;
      grad_in      = grad_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      score_in     = score_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      ph_in        = ph_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      l_we         = 1'b0;
      r_we         = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      rd_addr      = idx_ff;
      dreq         = '0;
      sum65        = {1'b0, score_ff} + {1'b0, drsp.quotient};
      case (state_ff)
         tsl2_pkg::ST_ACCUM: begin
            if (start) begin
               idx_in  = comp_ff[AW-1:0];
               rd_addr = idx_in;
               side_in = go_right;
               last_in = req_beat.sample_last;
               grad_in = req_beat.grad_value;
               if (req_beat.sample_last || (comp_ff + 1'b1 >= n_act)) begin
                  comp_in = '0;
                  if (go_right) begin
                     if (32'(rcnt_ff) < MAX_SAMPLES) rcnt_in = rcnt_ff + 1'b1;
                  end else begin
                     if (32'(lcnt_ff) < MAX_SAMPLES) lcnt_in = lcnt_ff + 1'b1;
                  end
               end else begin
                  comp_in = comp_ff + 1'b1;
               end
               state_in = tsl2_pkg::ST_READ;
            end
         end
         tsl2_pkg::ST_READ: begin
            if (acc[SW] != acc[SW-1]) begin
               wr_data = acc[SW] ? SumMin : SumMax;
            end else begin
               wr_data = acc[SW-1:0];
            end
            l_we = !side_ff;
            r_we = side_ff;
            if (last_ff) begin
               score_in = '0;
               idx_in   = '0;
               side_in  = 1'b0;
               ph_in    = '0;
               state_in = rej ? tsl2_pkg::ST_CLEAR : tsl2_pkg::ST_TERM;
            end else begin
               state_in = tsl2_pkg::ST_ACCUM;
            end
         end
         tsl2_pkg::ST_TERM: begin
            // Phase 0 reads, phase 1 takes the magnitude, 2 and 3 square.
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  mag_in = cur[SW-1] ? (~cur + 1'b1) : cur;
                  ph_in  = 2'd2;
               end
               2'd2: begin
                  sq_in = {48'd0, pb * pb} + ({48'd0, pa * pb} << 25);
                  ph_in = 2'd3;
               end
               default: begin
                  sq_in = sq_ff + ({48'd0, pa * pa} << 48);
                  ph_in = 2'd0;
                  if ((side_ff ? rcnt_ff : lcnt_ff) == '0) begin
                     state_in = tsl2_pkg::ST_DIV;
                     sum65    = {1'b0, score_ff};
                  end else begin
                     dreq.start    = 1'b1;
                     dreq.dividend = sq_in;
                     dreq.divisor  = 37'(side_ff ? rcnt_ff : lcnt_ff) << 16;
                     state_in      = tsl2_pkg::ST_DIV;
                  end
               end
            endcase
         end
         tsl2_pkg::ST_DIV: begin
            if (drsp.done || (side_ff ? rcnt_ff : lcnt_ff) == '0) begin
               if ((side_ff ? rcnt_ff : lcnt_ff) != '0) begin
                  if (drsp.overflow || sum65[64]) begin
                     score_in = '1;
                  end else begin
                     score_in = sum65[63:0];
                  end
               end
               if (side_ff) begin
                  side_in = 1'b0;
                  if ({1'b0, idx_ff} + 1'b1 >= n_act) begin
                     idx_in   = '0;
                     state_in = tsl2_pkg::ST_CLEAR;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = tsl2_pkg::ST_TERM;
                  end
               end else begin
                  side_in  = 1'b1;
                  state_in = tsl2_pkg::ST_TERM;
               end
               rd_addr = idx_in;
            end
         end
         tsl2_pkg::ST_CLEAR: begin
            l_we    = 1'b1;
            r_we    = 1'b1;
            wr_data = '0;
            if (32'(idx_ff) == MAX_OUTPUTS - 1) begin
               idx_in   = '0;
               state_in = last_ff ? tsl2_pkg::ST_DONE : tsl2_pkg::ST_ACCUM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tsl2_pkg::ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.split_score = rej ? 64'd0 : score_ff;
            rsp_in.rejected    = rej;
            rsp_in.left_total  = 17'(lcnt_ff);
            rsp_in.right_total = 17'(rcnt_ff);
            lcnt_in  = '0;
            rcnt_in  = '0;
            comp_in  = '0;
            last_in  = 1'b0;
            state_in = tsl2_pkg::ST_ACCUM;
         end
         default: state_in = tsl2_pkg::ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsl2_pkg::ST_CLEAR;
         idx_ff       <= '0;
         comp_ff      <= '0;
         last_ff      <= 1'b0;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         side_ff      <= 1'b0;
         ph_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         comp_ff      <= comp_in;
         last_ff      <= last_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
         ph_ff        <= ph_in;
      end
      grad_ff  <= grad_in;
      score_ff <= score_in;
      sq_ff    <= sq_in;
      mag_ff   <= mag_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != tsl2_pkg::ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   a_result_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsl2_pkg::ST_DONE) |=> rsp_valid)
      else $error("result strobe missing after scoring");

   a_rejected_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat.rejected) |-> (rsp_beat.split_score == 64'd0))
      else $error("rejected split carries a score");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsl2_pkg::ST_READ) |-> busy)
      else $error("beat accepted during write-back");

endmodule
